// File: src/atrm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// atrm_pkg
// Shared types, constants and helper functions of the modem reply matcher.
// ============================================================================
package atrm_pkg;

   // Reply store size. The byte counter holds values up to BUFFER_SIZE-1.
   localparam int BUFFER_SIZE = 512;
   localparam int COUNT_W     = $clog2(BUFFER_SIZE);
   localparam int COUNT_MAX   = BUFFER_SIZE - 1;
   localparam int LEN_W       = 9;

   // Depth of the queues between the front, the back and the result port.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int WIN_DEPTH   = 9;
   localparam int TICK_W      = 16;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Seen flag bit positions.
   localparam int FLAG_OK    = 0;
   localparam int FLAG_ERROR = 1;
   localparam int FLAG_FAIL  = 2;
   localparam int FLAG_J1    = 3;
   localparam int FLAG_J2    = 4;
   localparam int FLAG_J3    = 5;
   localparam int FLAG_J4    = 6;
   localparam int FLAG_W     = 7;

   // Patterns, last character in the low byte, padded with zeros above.
   localparam logic [8*WIN_DEPTH-1:0] PAT_OK = {56'h0, "OK"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_ERROR = {32'h0, "ERROR"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_FAIL = {40'h0, "FAIL"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_J1 = {8'h0, "+CWJAP:1"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_J2 = {8'h0, "+CWJAP:2"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_J3 = {8'h0, "+CWJAP:3"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_J4 = {8'h0, "+CWJAP:4"};
   localparam logic [8*WIN_DEPTH-1:0] PAT_END_OK =
      {24'h0, 8'h0D, 8'h0A, "OK", 8'h0D, 8'h0A};
   localparam logic [8*WIN_DEPTH-1:0] PAT_END_ERROR =
      {8'h0D, 8'h0A, "ERROR", 8'h0D, 8'h0A};
   localparam logic [8*WIN_DEPTH-1:0] PAT_END_FAIL =
      {8'h0, 8'h0D, 8'h0A, "FAIL", 8'h0D, 8'h0A};

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_CMD_ERROR    = 3'd1,
      ST_TIMEOUT      = 3'd2,
      ST_BAD_PASSWORD = 3'd3,
      ST_NOT_FOUND    = 3'd4,
      ST_CONNECT_FAIL = 3'd5,
      ST_OVERFLOW     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_BYTE,
      OP_TICK,
      OP_NONE
   } op_type;

   // One classified transaction, as queued between front and back.
   typedef struct packed {
      op_type            op;
      logic [7:0]        rx_byte;
      logic              byte_zero;
      logic [TICK_W-1:0] timeout_ticks;
      logic              tmo_zero;
   } op_item_type;

   typedef struct packed {
      logic             done_res;
      status_type       status;
      logic [LEN_W-1:0] length;
   } result_type;

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   // True when the newest len bytes of the window equal the pattern.
   function automatic logic ends_with(input window_type win,
                                      input logic [8*WIN_DEPTH-1:0] pat,
                                      input logic [3:0] len);
      logic hit;
      hit = 1'b1;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if ((4'(i) < len) && (win[i] != pat[8*i +: 8])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   function automatic status_type classify(input logic [FLAG_W-1:0] flags);
      status_type st;
      priority if (flags[FLAG_OK]) begin
         st = ST_OK;
      end else if (flags[FLAG_ERROR] || flags[FLAG_FAIL]) begin
         st = ST_CMD_ERROR;
      end else if (flags[FLAG_J1]) begin
         st = ST_TIMEOUT;
      end else if (flags[FLAG_J2]) begin
         st = ST_BAD_PASSWORD;
      end else if (flags[FLAG_J3]) begin
         st = ST_NOT_FOUND;
      end else if (flags[FLAG_J4]) begin
         st = ST_CONNECT_FAIL;
      end else begin
         st = ST_TIMEOUT;
      end
      return st;
   endfunction

endpackage

// File: src/atrm_front.sv
`timescale 1ns / 1ps
// ============================================================================
// atrm_front
// Accepts request transactions, decodes the command and queues the
// classified transaction for the matcher back end.
// ============================================================================
module atrm_front
   import atrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_rx_byte,
   input  logic [TICK_W-1:0] req_timeout_ticks,
   input  logic              item_deq,
   output logic              item_valid,
   output op_item_type       item
);

   op_item_type              qmem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   op_item_type              decoded;
   logic                     do_push;

   always_comb begin
      decoded.rx_byte       = req_rx_byte;
      decoded.byte_zero     = (req_rx_byte == 8'd0);
      decoded.timeout_ticks = req_timeout_ticks;
      decoded.tmo_zero      = (req_timeout_ticks == '0);
      unique case (req_cmd)
         CMD_START: decoded.op = OP_START;
         CMD_BYTE:  decoded.op = OP_BYTE;
         CMD_TICK:  decoded.op = OP_TICK;
         default:   decoded.op = OP_NONE;
      endcase
   end

   assign req_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push    = req_push && !req_full;
   assign item_valid = (count_ff != '0);
   assign item       = qmem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = item_deq ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(item_deq);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         qmem_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/atrm_back.sv
`timescale 1ns / 1ps
// ============================================================================
// atrm_back
// Reply matcher state: recent-byte window, seen flags, counters, completion
// decision. Handles one queued transaction per cycle unless res_full is set.
// ============================================================================
module atrm_back
   import atrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  op_item_type item,
   output logic        item_deq,
   input  logic        res_full,
   output logic        res_wr,
   output result_type  res
);

   window_type          window_ff, window_in;
   logic [FLAG_W-1:0]   flags_ff, flags_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]   limit_ff, limit_in;
   logic                waiting_ff, waiting_in;
   logic                text_ended_ff, text_ended_in;

   window_type          shifted;
   logic [FLAG_W-1:0]   hits;
   logic                end_hit;
   logic [TICK_W-1:0]   elapsed_inc;

   assign item_deq = item_valid && !res_full;
   assign res_wr   = item_deq;

   assign shifted     = {window_ff[WIN_DEPTH-2:0], item.rx_byte};
   assign elapsed_inc = elapsed_ff + TICK_W'(1);

   always_comb begin
      hits[FLAG_OK]    = ends_with(shifted, PAT_OK, 4'd2);
      hits[FLAG_ERROR] = ends_with(shifted, PAT_ERROR, 4'd5);
      hits[FLAG_FAIL]  = ends_with(shifted, PAT_FAIL, 4'd4);
      hits[FLAG_J1]    = ends_with(shifted, PAT_J1, 4'd8);
      hits[FLAG_J2]    = ends_with(shifted, PAT_J2, 4'd8);
      hits[FLAG_J3]    = ends_with(shifted, PAT_J3, 4'd8);
      hits[FLAG_J4]    = ends_with(shifted, PAT_J4, 4'd8);
      end_hit = ends_with(shifted, PAT_END_OK, 4'd6) ||
                ends_with(shifted, PAT_END_ERROR, 4'd9) ||
                ends_with(shifted, PAT_END_FAIL, 4'd8);
   end

   always_comb begin
      window_in     = window_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      elapsed_in    = elapsed_ff;
      limit_in      = limit_ff;
      waiting_in    = waiting_ff;
      text_ended_in = text_ended_ff;
      res.done_res  = 1'b0;
      res.status    = ST_OK;
      if (item_deq) begin
         unique case (item.op)
            OP_START: begin
               window_in     = '0;
               flags_in      = '0;
               count_in      = '0;
               elapsed_in    = '0;
               limit_in      = item.timeout_ticks;
               text_ended_in = 1'b0;
               waiting_in    = !item.tmo_zero;
               if (item.tmo_zero) begin
                  res.done_res = 1'b1;
                  res.status   = ST_TIMEOUT;
               end
            end
            OP_BYTE: begin
               if (waiting_ff) begin
                  if (count_ff == COUNT_W'(COUNT_MAX)) begin
                     waiting_in   = 1'b0;
                     res.done_res = 1'b1;
                     res.status   = ST_OVERFLOW;
                  end else begin
                     count_in      = count_ff + COUNT_W'(1);
                     window_in     = shifted;
                     text_ended_in = text_ended_ff || item.byte_zero;
                     // Once a zero byte has been seen, matching stays frozen.
                     if (!text_ended_in) begin
                        flags_in = flags_ff | hits;
                        if (end_hit) begin
                           waiting_in   = 1'b0;
                           res.done_res = 1'b1;
                           res.status   = classify(flags_in);
                        end
                     end
                  end
               end
            end
            OP_TICK: begin
               if (waiting_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= limit_ff) begin
                     waiting_in   = 1'b0;
                     res.done_res = 1'b1;
                     res.status   = classify(flags_ff);
                  end
               end
            end
            OP_NONE: begin
            end
         endcase
      end
      res.length = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         flags_ff      <= '0;
         count_ff      <= '0;
         elapsed_ff    <= '0;
         limit_ff      <= '0;
         waiting_ff    <= 1'b0;
         text_ended_ff <= 1'b0;
      end else begin
         window_ff     <= window_in;
         flags_ff      <= flags_in;
         count_ff      <= count_in;
         elapsed_ff    <= elapsed_in;
         limit_ff      <= limit_in;
         waiting_ff    <= waiting_in;
         text_ended_ff <= text_ended_in;
      end
   end

endmodule

// File: src/atrm_rsp_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// atrm_rsp_queue
// Result queue in front of the response port; lets the matcher run on
// while a finished result waits to be popped.
// ============================================================================
module atrm_rsp_queue
   import atrm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             res_wr,
   input  result_type       res,
   output logic             res_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic             rsp_done_res,
   output logic [2:0]       rsp_status,
   output logic [LEN_W-1:0] rsp_length
);

   result_type          qmem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;
   result_type          head;

   assign res_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;

   assign head         = qmem_ff[rd_ptr_ff];
   assign rsp_done_res = head.done_res;
   assign rsp_status   = head.status;
   assign rsp_length   = head.length;

   always_comb begin
      wr_ptr_in = res_wr ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(res_wr) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (res_wr) begin
         qmem_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/at_response_matcher.sv
`timescale 1ns / 1ps
// ============================================================================
// at_response_matcher
// Modem reply matcher: counts received bytes, matches the recent-byte
// window against reply patterns and reports when and how a reply ends.
//
//   Channel   Direction  Handshake        Fields
//   req_      in         push / full      cmd, rx_byte, timeout_ticks
//   rsp_      out        empty / pop      done_res, status, length
//
// One transaction per cycle sustained while results are popped; a request
// passes through the front queue, then the matcher writes its result into
// the result queue, from which it is popped. The matcher window compare is
// combinational. Reset clears both queues and all matcher state.
// full rises when the front queue holds two transactions; the matcher stops
// while the result queue is full, so a stalled pop backs up to the input.
// ============================================================================
module at_response_matcher
   import atrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_rx_byte,
   input  logic [TICK_W-1:0] req_timeout_ticks,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_done_res,
   output logic [2:0]        rsp_status,
   output logic [LEN_W-1:0]  rsp_length
);

   logic        item_valid;
   logic        item_deq;
   op_item_type item;
   logic        res_wr;
   logic        res_full;
   result_type  res;

   atrm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .req_timeout_ticks (req_timeout_ticks),
      .item_deq          (item_deq),
      .item_valid        (item_valid),
      .item              (item)
   );

   atrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_deq   (item_deq),
      .res_full   (res_full),
      .res_wr     (res_wr),
      .res        (res)
   );

   atrm_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .res_wr       (res_wr),
      .res          (res),
      .res_full     (res_full),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_done_res (rsp_done_res),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length)
   );

endmodule

// File: tb/sv/at_response_matcher_test.sv
`timescale 1ns / 1ps
// ============================================================================
// at_response_matcher_test
// Self-checking bench for the modem reply matcher. Requests are pushed with
// random gaps and results are popped with random stalls. A model of the
// matcher kept in this file predicts every result as its request is
// accepted, and each popped result is compared field by field in order.
// ============================================================================
module at_response_matcher_test;
   import atrm_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         STORE_LIMIT  = BUFFER_SIZE - 1;
   localparam int         ITEM_TARGET  = 1650;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         QUIET_LIMIT  = 4000;
   localparam int         REPORT_LIMIT = 200;

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_push          = 1'b0;
   logic              req_full;
   logic [1:0]        req_cmd           = CMD_START;
   logic [7:0]        req_rx_byte       = 8'h00;
   logic [TICK_W-1:0] req_timeout_ticks = '0;
   logic              rsp_empty;
   logic              rsp_pop           = 1'b0;
   logic              rsp_done_res;
   logic [2:0]        rsp_status;
   logic [LEN_W-1:0]  rsp_length;

   at_response_matcher dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .req_timeout_ticks (req_timeout_ticks),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_done_res      (rsp_done_res),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length)
   );

   // Matcher state as predicted by the bench. recent_rx[0] is the newest byte.
   // The initial values are the state right after reset.
   logic [7:0]        recent_rx [WIN_DEPTH] = '{default: 8'h00};
   logic [FLAG_W-1:0] seen_words    = '0;
   logic [LEN_W-1:0]  stored_count  = '0;
   logic [TICK_W-1:0] tick_count    = '0;
   logic [TICK_W-1:0] tick_limit    = '0;
   logic              reply_waiting = 1'b0;
   logic              text_frozen   = 1'b0;

   result_type expected_replies [$];
   int         mismatch_count     = 0;
   int         items_sent         = 0;
   int         sender_idle_pct    = 0;
   int         receiver_stall_pct = 0;
   int         hold_requests      = 0;
   int         quiet_cycles       = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic logic tail_is(input string pat);
      int n;
      n = pat.len();
      for (int i = 0; i < n; i++) begin
         if (recent_rx[i] != pat[n - 1 - i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic status_type reply_status(input logic [FLAG_W-1:0] seen);
      if (seen[FLAG_OK]) return ST_OK;
      if (seen[FLAG_ERROR] || seen[FLAG_FAIL]) return ST_CMD_ERROR;
      if (seen[FLAG_J1]) return ST_TIMEOUT;
      if (seen[FLAG_J2]) return ST_BAD_PASSWORD;
      if (seen[FLAG_J3]) return ST_NOT_FOUND;
      if (seen[FLAG_J4]) return ST_CONNECT_FAIL;
      return ST_TIMEOUT;
   endfunction

   function automatic result_type predict_reply(input logic [1:0] cmd,
                                                input logic [7:0] rx,
                                                input logic [TICK_W-1:0] tmo);
      result_type r;
      r.done_res = 1'b0;
      r.status   = ST_OK;
      case (cmd)
         CMD_START: begin
            for (int i = 0; i < WIN_DEPTH; i++) recent_rx[i] = 8'h00;
            seen_words   = '0;
            stored_count = '0;
            tick_count   = '0;
            tick_limit   = tmo;
            text_frozen  = 1'b0;
            reply_waiting = (tmo != 0);
            if (tmo == 0) begin
               r.done_res = 1'b1;
               r.status   = ST_TIMEOUT;
            end
         end
         CMD_BYTE: begin
            if (reply_waiting && int'(stored_count) >= STORE_LIMIT) begin
               reply_waiting = 1'b0;
               r.done_res    = 1'b1;
               r.status      = ST_OVERFLOW;
            end else if (reply_waiting) begin
               stored_count = stored_count + LEN_W'(1);
               for (int i = WIN_DEPTH - 1; i > 0; i--) recent_rx[i] = recent_rx[i - 1];
               recent_rx[0] = rx;
               if (rx == 8'h00) text_frozen = 1'b1;
               if (!text_frozen) begin
                  if (tail_is("OK")) seen_words[FLAG_OK] = 1'b1;
                  if (tail_is("ERROR")) seen_words[FLAG_ERROR] = 1'b1;
                  if (tail_is("FAIL")) seen_words[FLAG_FAIL] = 1'b1;
                  for (int d = 1; d <= 4; d++) begin
                     if (tail_is($sformatf("+CWJAP:%0d", d))) seen_words[FLAG_J1 + d - 1] = 1'b1;
                  end
                  if (tail_is("\015\012OK\015\012") || tail_is("\015\012ERROR\015\012") ||
                      tail_is("\015\012FAIL\015\012")) begin
                     reply_waiting = 1'b0;
                     r.done_res    = 1'b1;
                     r.status      = reply_status(seen_words);
                  end
               end
            end
         end
         CMD_TICK: begin
            if (reply_waiting) begin
               tick_count = tick_count + TICK_W'(1);
               if (tick_count >= tick_limit) begin
                  reply_waiting = 1'b0;
                  r.done_res    = 1'b1;
                  r.status      = reply_status(seen_words);
               end
            end
         end
         default: begin
         end
      endcase
      r.length = stored_count;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // push stays high after a transaction; drain_replies lowers it before any wait.
   task automatic push_request(input logic [1:0] cmd, input logic [7:0] rx,
                               input logic [TICK_W-1:0] tmo);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push          <= 1'b1;
      req_cmd           <= cmd;
      req_rx_byte       <= rx;
      req_timeout_ticks <= tmo;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_replies.push_back(predict_reply(cmd, rx, tmo));
      items_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_request(CMD_BYTE, s[i], 16'($urandom));
   endtask

   task automatic push_noise(input int count);
      repeat (count) push_request(CMD_BYTE, 8'($urandom_range(8'h20, 8'h7E)), 16'($urandom));
   endtask

   task automatic push_ticks(input int max_ticks);
      for (int k = 0; k < max_ticks && reply_waiting; k++) begin
         push_request(CMD_TICK, 8'($urandom), 16'($urandom));
      end
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // One reply wait: mostly well-formed words and frames with random content,
   // some noise, zero bytes, stray commands and replies left unfinished.
   task automatic send_random_reply();
      int                pick;
      logic [TICK_W-1:0] tmo;
      pick = $urandom_range(0, 7);
      if (pick == 0) tmo = '0;
      else if (pick == 1) tmo = 16'($urandom);
      else tmo = 16'($urandom_range(1, 12));
      push_request(CMD_START, 8'($urandom), tmo);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 14))
            0, 1, 2: push_noise($urandom_range(1, 4));
            3, 4: push_text($sformatf("+CWJAP:%0d", $urandom_range(0, 5)));
            5: push_text("OK");
            6: push_text("\"OK\"");
            7: push_text("ERROR");
            8: push_text("FAIL");
            9, 10: push_text("\015\012");
            11: push_request(CMD_TICK, 8'($urandom), 16'($urandom));
            12: push_request(CMD_BYTE, 8'($urandom), 16'($urandom));
            13: push_request(CMD_UNUSED, 8'($urandom), 16'($urandom));
            default: push_request(CMD_BYTE, 8'h00, 16'($urandom));
         endcase
      end
      case ($urandom_range(0, 7))
         0, 1: push_text("\015\012OK\015\012");
         2: push_text("\015\012ERROR\015\012");
         3: push_text("\015\012FAIL\015\012");
         4, 5: push_ticks(16);
         6: push_text("\015\012OK\015");
         default: begin
         end
      endcase
      if ($urandom_range(0, 3) == 0) begin
         push_request(2'($urandom_range(1, 3)), 8'($urandom), 16'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_idle_commands();
      push_request(CMD_BYTE, 8'hFF, 16'hFFFF);
      push_request(CMD_TICK, 8'h00, 16'h0000);
      push_request(CMD_UNUSED, 8'hA5, 16'h5A5A);
   endtask

   task automatic test_zero_limit();
      push_request(CMD_START, 8'hFF, 16'h0000);
      push_request(CMD_TICK, 8'h00, 16'hFFFF);
   endtask

   task automatic test_framed_ok();
      push_request(CMD_START, 8'h00, 16'hFFFF);
      push_text("\015\012OK\015\012");
   endtask

   task automatic test_tick_timeout();
      push_request(CMD_START, 8'h00, 16'h0001);
      push_request(CMD_TICK, 8'hFF, 16'h0000);
   endtask

   // After a zero byte the frame below must neither match nor end the reply.
   task automatic test_zero_byte();
      push_request(CMD_START, 8'h00, 16'h0003);
      push_request(CMD_BYTE, 8'h00, 16'h0000);
      push_text("\015\012OK\015\012");
      push_ticks(3);
   endtask

   task automatic test_join_codes();
      for (int code = 1; code <= 4; code++) begin
         push_request(CMD_START, 8'($urandom), 16'($urandom_range(1, 4)));
         push_noise($urandom_range(0, 3));
         push_text($sformatf("+CWJAP:%0d", code));
         push_text("\015\012");
         push_ticks(8);
      end
   endtask

   task automatic test_store_full();
      push_request(CMD_START, 8'($urandom), 16'hFFFF);
      push_noise(STORE_LIMIT);
      push_request(CMD_BYTE, 8'($urandom), 16'($urandom));
      push_request(CMD_BYTE, 8'($urandom), 16'($urandom));
   endtask

   task automatic test_backpressure();
      int first;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      first = items_sent;
      hold_requests++;
      while (items_sent - first < 40) send_random_reply();
   endtask

   task automatic test_random_replies();
      int goal;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
            default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
         endcase
         goal = items_sent + (ITEM_TARGET - items_sent) / (4 - phase);
         while (items_sent < goal) send_random_reply();
         drain_replies();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      int holds_taken;
      hold_left   = 0;
      holds_taken = 0;
      forever begin
         @(negedge clock);
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   task automatic note_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      mismatch_count++;
      // A broken build would otherwise flood the log.
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: transaction expected none, actual done %0d status %0d length %0d",
                        $time, rsp_done_res, rsp_status, rsp_length);
            end
         end else begin
            want = expected_replies.pop_front();
            if (rsp_done_res !== want.done_res) begin
               note_mismatch("done_res", 16'(want.done_res), 16'(rsp_done_res));
            end
            if (rsp_status !== want.status) begin
               note_mismatch("status", 16'(want.status), 16'(rsp_status));
            end
            if (rsp_length !== want.length) begin
               note_mismatch("length", 16'(want.length), 16'(rsp_length));
            end
         end
      end
   end

   // Watchdog: cycles in which neither side completes a transaction.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_zero_limit();
      test_framed_ok();
      test_tick_timeout();
      test_zero_byte();
      drain_replies();
      test_join_codes();
      drain_replies();
      test_store_full();
      drain_replies();
      test_backpressure();
      drain_replies();
      test_random_replies();
      drain_replies();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
src/atrm_pkg.sv
src/atrm_front.sv
src/atrm_back.sv
src/atrm_rsp_queue.sv
src/at_response_matcher.sv
tb/sv/at_response_matcher_test.sv
